// ===== rtl/slfr_pkg.sv =====
`default_nettype none

package slfr_pkg;

    localparam int MAX_PAYLOAD    = 248;
    localparam int FRAME_DEPTH    = 256;
    localparam int HDR_BYTES      = 6;
    localparam int OVERHEAD_BYTES = 8;
    localparam int ADDR_W         = $clog2(FRAME_DEPTH);
    localparam int LEN_W          = $clog2(FRAME_DEPTH + 1);

    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_TICK    = 3'd1;
    localparam logic [2:0] KIND_LERR    = 3'd2;
    localparam logic [2:0] KIND_READ    = 3'd3;
    localparam logic [2:0] KIND_RELEASE = 3'd4;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_DONE      = 3'd1;
    localparam logic [2:0] EV_DROP      = 3'd2;
    localparam logic [2:0] EV_GAP       = 3'd3;
    localparam logic [2:0] EV_LENGTH    = 3'd4;
    localparam logic [2:0] EV_LINE_ERR  = 3'd5;
    localparam logic [2:0] EV_BAD_INDEX = 3'd6;

    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_GAP_TIMEOUT = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              done;
        logic [LEN_W-1:0]  total;
        logic [2:0]        ev;
    } slfr_req_t;

endpackage

`default_nettype wire

// ===== rtl/slfr_parser.sv =====
`default_nettype none

module slfr_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_en,
    input  wire logic              tick_en,
    input  wire logic              lerr_en,
    input  wire logic [7:0]        byte_value,
    input  wire logic [7:0]        sync_first,
    input  wire logic [7:0]        sync_second,
    input  wire logic [7:0]        gap_timeout,
    output slfr_pkg::slfr_req_t    req
);
    import slfr_pkg::*;

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_TYPE,
        PH_CMD,
        PH_LENL,
        PH_LENH,
        PH_PAY,
        PH_CRCL,
        PH_CRCH
    } phase_t;

    phase_t     phase_reg, phase_next, phase_eff;
    logic       first_seen_reg, first_seen_next, first_seen_eff;
    logic [7:0] pay_len_reg, pay_len_next, pay_len_eff;
    logic [7:0] len_low_reg, len_low_next, len_low_eff;
    logic [7:0] pay_cnt_reg, pay_cnt_next, pay_cnt_eff;
    logic [7:0] ticks_reg, ticks_next;
    logic       gap_hit;
    logic [15:0] len16;
    logic [7:0]  pay_cnt_inc;

    assign gap_hit = byte_en && ((phase_reg != PH_SYNC) || first_seen_reg)
                     && (ticks_reg > gap_timeout);
    assign len16       = {byte_value, len_low_eff};
    assign pay_cnt_inc = pay_cnt_eff + 8'd1;

    // restart before parsing when the gap expired
    always_comb
    begin
        if (gap_hit)
        begin
            phase_eff      = PH_SYNC;
            first_seen_eff = 1'b0;
            pay_len_eff    = '0;
            len_low_eff    = '0;
            pay_cnt_eff    = '0;
        end
        else
        begin
            phase_eff      = phase_reg;
            first_seen_eff = first_seen_reg;
            pay_len_eff    = pay_len_reg;
            len_low_eff    = len_low_reg;
            pay_cnt_eff    = pay_cnt_reg;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        first_seen_next = first_seen_reg;
        pay_len_next    = pay_len_reg;
        len_low_next    = len_low_reg;
        pay_cnt_next    = pay_cnt_reg;
        ticks_next      = ticks_reg;
        req             = '0;
        req.wr_data     = byte_value;

        if (byte_en)
        begin
            phase_next      = phase_eff;
            first_seen_next = first_seen_eff;
            pay_len_next    = pay_len_eff;
            len_low_next    = len_low_eff;
            pay_cnt_next    = pay_cnt_eff;
            ticks_next      = '0;
            req.ev          = gap_hit ? EV_GAP : EV_NONE;

            case (phase_eff)
                PH_SYNC:
                begin
                    if (first_seen_eff && (byte_value == sync_second))
                    begin
                        req.wr_en       = 1'b1;
                        req.wr_addr     = ADDR_W'(1);
                        first_seen_next = 1'b0;
                        phase_next      = PH_TYPE;
                    end
                    else if (byte_value == sync_first)
                    begin
                        req.wr_en       = 1'b1;
                        req.wr_addr     = '0;
                        first_seen_next = 1'b1;
                    end
                    else
                    begin
                        first_seen_next = 1'b0;
                    end
                end
                PH_TYPE:
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = ADDR_W'(2);
                    phase_next  = PH_CMD;
                end
                PH_CMD:
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = ADDR_W'(3);
                    phase_next  = PH_LENL;
                end
                PH_LENL:
                begin
                    req.wr_en    = 1'b1;
                    req.wr_addr  = ADDR_W'(4);
                    len_low_next = byte_value;
                    phase_next   = PH_LENH;
                end
                PH_LENH:
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = ADDR_W'(5);
                    if ((len16 > 16'(MAX_PAYLOAD)) ||
                        ({1'b0, len16} + 17'(OVERHEAD_BYTES) > 17'(FRAME_DEPTH)))
                    begin
                        phase_next      = PH_SYNC;
                        first_seen_next = 1'b0;
                        pay_len_next    = '0;
                        len_low_next    = '0;
                        pay_cnt_next    = '0;
                        req.ev          = EV_LENGTH;
                    end
                    else
                    begin
                        pay_len_next = len16[7:0];
                        pay_cnt_next = '0;
                        phase_next   = (len16 == 16'd0) ? PH_CRCL : PH_PAY;
                    end
                end
                PH_PAY:
                begin
                    req.wr_en    = 1'b1;
                    req.wr_addr  = ADDR_W'(HDR_BYTES) + ADDR_W'(pay_cnt_eff);
                    pay_cnt_next = pay_cnt_inc;
                    if (pay_cnt_inc >= pay_len_eff)
                    begin
                        phase_next = PH_CRCL;
                    end
                end
                PH_CRCL:
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = ADDR_W'(HDR_BYTES) + ADDR_W'(pay_len_eff);
                    phase_next  = PH_CRCH;
                end
                PH_CRCH:
                begin
                    req.wr_en       = 1'b1;
                    req.wr_addr     = ADDR_W'(HDR_BYTES + 1) + ADDR_W'(pay_len_eff);
                    req.done        = 1'b1;
                    req.total       = LEN_W'(OVERHEAD_BYTES) + LEN_W'(pay_len_eff);
                    phase_next      = PH_SYNC;
                    first_seen_next = 1'b0;
                    pay_len_next    = '0;
                    len_low_next    = '0;
                    pay_cnt_next    = '0;
                end
                default:
                begin
                    phase_next = PH_SYNC;
                end
            endcase
        end
        else if (tick_en)
        begin
            // saturate
            if (ticks_reg != 8'hFF)
            begin
                ticks_next = ticks_reg + 8'd1;
            end
        end
        else if (lerr_en)
        begin
            phase_next      = PH_SYNC;
            first_seen_next = 1'b0;
            pay_len_next    = '0;
            len_low_next    = '0;
            pay_cnt_next    = '0;
            ticks_next      = '0;
            req.ev          = EV_LINE_ERR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC;
            first_seen_reg <= 1'b0;
            pay_len_reg    <= '0;
            len_low_reg    <= '0;
            pay_cnt_reg    <= '0;
            ticks_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            first_seen_reg <= first_seen_next;
            pay_len_reg    <= pay_len_next;
            len_low_reg    <= len_low_next;
            pay_cnt_reg    <= pay_cnt_next;
            ticks_reg      <= ticks_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sync_length_frame_receiver.sv =====
// The result item is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while out_stall is low; the frame memory has one write and one read port.
// Completed frames swap banks in the frame memory, so no copy pass is needed.
// Reset: parser idle, no frame held, sync bytes 170 and 85, gap timeout 5.
// Frame memory contents are not cleared; no clearing pass after reset.
`default_nettype none

module sync_length_frame_receiver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] kind,
    input  wire logic [7:0] byte_value,
    input  wire logic [7:0] read_index,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            frame_ready,
    output logic [8:0]      frame_length,
    output logic [7:0]      read_byte,
    output logic [2:0]      event_res,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import slfr_pkg::*;

    logic             accept;
    slfr_req_t        req;
    logic [7:0]       sync_first_reg, sync_second_reg, gap_timeout_reg;
    logic             asm_bank_reg, asm_bank_next;
    logic             cvalid_reg, cvalid_next;
    logic [LEN_W-1:0] clen_reg, clen_next;
    logic             out_valid_reg;
    logic [2:0]       event_reg, event_next;
    logic             rd_good_reg, rd_good_next;
    logic [7:0]       rd_data_reg;
    logic             read_ok;
    logic             rd_en;

    logic [7:0] frame_mem [2*FRAME_DEPTH];

    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    slfr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_en     (accept && (kind == KIND_BYTE)),
        .tick_en     (accept && (kind == KIND_TICK)),
        .lerr_en     (accept && (kind == KIND_LERR)),
        .byte_value  (byte_value),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .gap_timeout (gap_timeout_reg),
        .req         (req)
    );

    assign read_ok = cvalid_reg && ({1'b0, read_index} < clen_reg);
    assign rd_en   = accept && (kind == KIND_READ) && read_ok;

    always_comb
    begin
        asm_bank_next = asm_bank_reg;
        cvalid_next   = cvalid_reg;
        clen_next     = clen_reg;
        event_next    = EV_NONE;
        rd_good_next  = 1'b0;
        case (kind)
            KIND_BYTE:
            begin
                event_next = req.ev;
                if (req.done)
                begin
                    if (cvalid_reg)
                    begin
                        event_next = EV_DROP;
                    end
                    else
                    begin
                        cvalid_next   = 1'b1;
                        clen_next     = req.total;
                        asm_bank_next = !asm_bank_reg;
                        event_next    = EV_DONE;
                    end
                end
            end
            KIND_TICK,
            KIND_LERR:
            begin
                event_next = req.ev;
            end
            KIND_READ:
            begin
                if (read_ok)
                begin
                    rd_good_next = 1'b1;
                end
                else
                begin
                    event_next = EV_BAD_INDEX;
                end
            end
            KIND_RELEASE:
            begin
                cvalid_next = 1'b0;
                clen_next   = '0;
            end
            default:
            begin
                event_next = EV_NONE;
            end
        endcase
    end

    // assembly writes the open bank, reads come from the completed bank
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            frame_mem[{asm_bank_reg, req.wr_addr}] <= req.wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[{!asm_bank_reg, read_index}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= 8'd170;
            sync_second_reg <= 8'd85;
            gap_timeout_reg <= 8'd5;
            asm_bank_reg    <= 1'b0;
            cvalid_reg      <= 1'b0;
            clen_reg        <= '0;
            out_valid_reg   <= 1'b0;
            event_reg       <= EV_NONE;
            rd_good_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                    REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                    REG_GAP_TIMEOUT: gap_timeout_reg <= cfg_data;
                    default:         sync_first_reg  <= sync_first_reg;
                endcase
            end
            if (accept)
            begin
                asm_bank_reg  <= asm_bank_next;
                cvalid_reg    <= cvalid_next;
                clen_reg      <= clen_next;
                out_valid_reg <= 1'b1;
                event_reg     <= event_next;
                rd_good_reg   <= rd_good_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_ready  = cvalid_reg;
    assign frame_length = clen_reg;
    assign event_res    = event_reg;
    assign read_byte    = rd_good_reg ? rd_data_reg : 8'd0;

    a_done_holds_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_DONE) |-> frame_ready && (frame_length != 9'd0))
        else $error("frame done without a held frame");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == KIND_RELEASE) |=> !frame_ready && (frame_length == 9'd0))
        else $error("release did not clear the completed frame");

    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == KIND_BYTE) && req.done && !cvalid_reg
        |=> asm_bank_reg != $past(asm_bank_reg))
        else $error("completed frame did not swap banks");

    a_bad_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_BAD_INDEX) |-> read_byte == 8'd0)
        else $error("bad index returned data");

endmodule

`default_nettype wire
